// ===== hw/rtl/gre_pkg.sv =====
// ----------------------------------------------------------------------------
// gre_pkg: shared types and constants for the gamma ramp entry block
// Fixed-point formats, register indexes and the root constant table used
// by the exp2 stages.
// ----------------------------------------------------------------------------
package gre_pkg;

	localparam int REG_W      = 16;  // width of every configuration register
	localparam int LEVEL_W    = 16;  // output level width
	localparam int CFG_IDX_W  = 2;
	localparam int MANT_BITS  = 30;  // mantissa is Q1.30
	localparam int LOG_FRAC   = 16;  // fraction bits of log2 / exponent
	localparam int MIN_EXP    = -17; // smaller integer exponent gives level 0
	localparam int LI_W       = 8;   // signed integer part of log2(x)

	typedef logic [REG_W-1:0]     reg_t;
	typedef logic [LEVEL_W-1:0]   level_t;
	typedef logic [MANT_BITS:0]   mant_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BRIGHTNESS = 2'd0,
		REG_CONTRAST   = 2'd1,
		REG_INV_GAMMA  = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_idx_t;

	localparam level_t LEVEL_MAX = '1;

	// Integer square root, used only to build constants at elaboration.
	function automatic longint unsigned isqrt64(input longint unsigned v_in);
		longint unsigned v;
		longint unsigned res;
		longint unsigned bitv;
		v    = v_in;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// 2^(2^-k) in Q1.30, each the truncated square root of the one before.
	function automatic mant_t root_const(input int k);
		longint unsigned c;
		c = isqrt64(64'd2 << (2 * MANT_BITS));
		for (int i = 1; i < k; i++)
			c = isqrt64(c << MANT_BITS);
		return mant_t'(c);
	endfunction

endpackage

// ===== hw/rtl/gre_if.sv =====
// ----------------------------------------------------------------------------
// gre_index_if / gre_level_if: item channels of the gamma ramp entry block
// Valid/ready channels carrying a ramp index in and a ramp level out.
// ----------------------------------------------------------------------------
interface gre_index_if import gre_pkg::*; #(parameter int INDEX_BITS = 8);
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] ramp_index;

	modport source (output valid, output ramp_index, input ready);
	modport sink   (input valid, input ramp_index, output ready);
endinterface

interface gre_level_if import gre_pkg::*;;
	logic   valid;
	logic   ready;
	level_t ramp_level;

	modport source (output valid, output ramp_level, input ready);
	modport sink   (input valid, input ramp_level, output ready);
endinterface

// ===== hw/rtl/gamma_ramp_entry.sv =====
// ----------------------------------------------------------------------------
// gamma_ramp_entry: brightness / contrast / gamma ramp entry generator
// Pipelined fixed-point evaluation of ((0.5 + c*(f*b - 0.5)) ^ inv_gamma).
// ----------------------------------------------------------------------------
// Usage:
//   req carries one ramp index per item; rsp returns one 16-bit level per
//   item, in order. Registers brightness, contrast and 1/gamma (Q4.12) are to
//   be written through wr_en / wr_index / wr_data only while no item is in
//   flight; the block itself does not enforce this.
// Throughput: one item per clock. Every stage is a single register with a
//   valid bit; the whole pipe advances together whenever the output register
//   is empty or rsp takes its item.
// Depth: 38 register stages, mostly set by the 16 square-and-compare log2
//   stages and the 16 conditional-multiply exp2 stages, each built around
//   one 31x31 multiplier.
// Stalls: while rsp holds ready low with an item waiting, the pipe freezes
//   and req.ready drops; nothing is lost or repeated.
// Reset: arst_n clears all valid bits at once and loads the registers with
//   1.0 each. No clearing pass is needed.
// Special cases: x at or below zero gives 0; an exponent result of one or
//   more saturates to 65535; an integer exponent below -17 gives 0.
// ----------------------------------------------------------------------------
module gamma_ramp_entry import gre_pkg::*; #(
	parameter int INDEX_BITS = 8,
	parameter int FRAC_BITS  = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	gre_index_if.sink            req,
	gre_level_if.source          rsp,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  reg_t                 wr_data
);

	localparam int T_W    = INDEX_BITS + REG_W;          // idx * brightness
	localparam int D_W    = T_W + 1;                     // signed offset
	localparam int XN_W   = D_W + REG_W + 2;             // signed x numerator
	localparam int UX_W   = XN_W - 1;
	localparam int P_W    = $clog2(UX_W);
	localparam int SCALE  = INDEX_BITS + 2 * FRAC_BITS;
	localparam int LOGV_W = LI_W + LOG_FRAC;
	localparam int EP_W   = LOGV_W + REG_W + 1;
	localparam int SH_W   = 6;
	localparam int LVL_PW = MANT_BITS + 1 + LEVEL_W;
	// stage map: 1 mult, 2 mult-add, 3 normalize, log rounds, exponent,
	// exp rounds, scale, shift/clamp
	localparam int NST    = 3 + LOG_FRAC + 1 + LOG_FRAC + 2;

	localparam logic signed [D_W-1:0]  HALF_T = D_W'(1) <<< (INDEX_BITS + FRAC_BITS - 1);
	localparam logic signed [XN_W-1:0] HALF_X = XN_W'(1) <<< (SCALE - 1);
	localparam logic signed [EP_W-1:0] E_MIN  =
		EP_W'(MIN_EXP) <<< LOG_FRAC;

	// ---------------- configuration registers ----------------
	reg_t brightness_q, contrast_q, inv_gamma_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= REG_W'(1) << FRAC_BITS;
			contrast_q   <= REG_W'(1) << FRAC_BITS;
			inv_gamma_q  <= REG_W'(1) << FRAC_BITS;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_BRIGHTNESS: brightness_q <= wr_data;
				REG_CONTRAST:   contrast_q   <= wr_data;
				REG_INV_GAMMA:  inv_gamma_q  <= wr_data;
				default: ;      // drop writes to unused indexes
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	logic [NST-1:0] vld_q;
	logic           advance;

	// Advance the whole pipe unless the output item is stuck.
	assign advance   = !vld_q[NST-1] || rsp.ready;
	assign req.ready = advance;
	assign rsp.valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (advance) begin
			vld_q <= {vld_q[NST-2:0], req.valid};
		end
	end

	// ---------------- stage 1: t = idx * brightness ----------------
	logic [T_W-1:0] t_s1;

	always_ff @(posedge clk) begin
		if (advance) begin
			t_s1 <= req.ramp_index * brightness_q;
		end
	end

	// ---------------- stage 2: x numerator ----------------
	logic signed [XN_W-1:0] xn_s2;
	logic signed [D_W-1:0]  d_c;

	assign d_c = $signed({1'b0, t_s1}) - HALF_T;

	always_ff @(posedge clk) begin
		if (advance) begin
			xn_s2 <= XN_W'($signed({1'b0, contrast_q}) * d_c) + HALF_X;
		end
	end

	// ---------------- stage 3: leading one and normalize ----------------
	logic [UX_W-1:0]         ux_c;
	logic [P_W-1:0]          p_c;
	logic [UX_W+MANT_BITS:0] shl_c;

	assign ux_c = xn_s2[UX_W-1:0];

	always_comb begin
		p_c = '0;
		for (int i = 0; i < UX_W; i++) begin
			if (ux_c[i]) p_c = P_W'(i);
		end
	end

	// Place the leading one at bit MANT_BITS, truncating on right shifts.
	assign shl_c = {ux_c, {(MANT_BITS + 1){1'b0}}} >> (p_c + 1'b1);

	// Log pipeline arrays, index 0 is the stage-3 output.
	mant_t                  lg_m_s   [LOG_FRAC+1];
	logic [LOG_FRAC-1:0]    lg_f_s   [LOG_FRAC+1];
	logic signed [LI_W-1:0] lg_int_s [LOG_FRAC+1];
	logic                   lg_pos_s [LOG_FRAC+1];

	always_ff @(posedge clk) begin
		if (advance) begin
			lg_m_s[0]   <= shl_c[MANT_BITS:0];
			lg_f_s[0]   <= '0;
			lg_int_s[0] <= LI_W'($signed({1'b0, p_c})) - LI_W'(SCALE);
			lg_pos_s[0] <= (xn_s2 > 0);
		end
	end

	// ---------------- log2 fraction: square and compare ----------------
	for (genvar j = 0; j < LOG_FRAC; j++) begin : g_log
		logic [2*MANT_BITS+1:0] sq_c;
		logic [MANT_BITS+1:0]   s_c;

		assign sq_c = lg_m_s[j] * lg_m_s[j];
		assign s_c  = sq_c[2*MANT_BITS+1:MANT_BITS];

		always_ff @(posedge clk) begin
			if (advance) begin
				lg_m_s[j+1]   <= s_c[MANT_BITS+1] ? s_c[MANT_BITS+1:1] : s_c[MANT_BITS:0];
				lg_f_s[j+1]   <= {lg_f_s[j][LOG_FRAC-2:0], s_c[MANT_BITS+1]};
				lg_int_s[j+1] <= lg_int_s[j];
				lg_pos_s[j+1] <= lg_pos_s[j];
			end
		end
	end

	// ---------------- exponent: e = floor(log2(x) * inv_gamma) ----------------
	logic signed [LOGV_W-1:0] logv_c;
	logic signed [EP_W-1:0]   ep_c;
	logic signed [EP_W-1:0]   e_c;
	logic signed [SH_W-1:0]   n_c;

	assign logv_c = $signed({lg_int_s[LOG_FRAC], lg_f_s[LOG_FRAC]});
	assign ep_c   = EP_W'(logv_c * $signed({1'b0, inv_gamma_q}));
	assign e_c    = ep_c >>> FRAC_BITS;
	assign n_c    = e_c[LOG_FRAC +: SH_W];

	mant_t               ex_acc_s  [LOG_FRAC+1];
	logic [LOG_FRAC-1:0] ex_f_s    [LOG_FRAC+1];
	logic [SH_W-1:0]     ex_sh_s   [LOG_FRAC+1];
	logic                ex_zero_s [LOG_FRAC+1];
	logic                ex_sat_s  [LOG_FRAC+1];

	always_ff @(posedge clk) begin
		if (advance) begin
			ex_acc_s[0]  <= mant_t'(1) << MANT_BITS;
			ex_f_s[0]    <= e_c[LOG_FRAC-1:0];
			ex_sh_s[0]   <= SH_W'(MANT_BITS) - n_c;
			ex_sat_s[0]  <= lg_pos_s[LOG_FRAC] && (e_c >= 0);
			ex_zero_s[0] <= !lg_pos_s[LOG_FRAC] || (e_c < E_MIN);
		end
	end

	// ---------------- exp2 fraction: product of roots ----------------
	for (genvar j = 0; j < LOG_FRAC; j++) begin : g_exp
		localparam mant_t ROOT = root_const(j + 1);
		logic [2*MANT_BITS+1:0] pr_c;

		assign pr_c = ex_acc_s[j] * ROOT;

		always_ff @(posedge clk) begin
			if (advance) begin
				ex_acc_s[j+1]  <= ex_f_s[j][LOG_FRAC-1-j] ?
					pr_c[2*MANT_BITS:MANT_BITS] : ex_acc_s[j];
				ex_f_s[j+1]    <= ex_f_s[j];
				ex_sh_s[j+1]   <= ex_sh_s[j];
				ex_zero_s[j+1] <= ex_zero_s[j];
				ex_sat_s[j+1]  <= ex_sat_s[j];
			end
		end
	end

	// ---------------- scale by 65535 ----------------
	logic [LVL_PW-1:0] lp_s;
	logic [SH_W-1:0]   sh_s;
	logic              zero_s, sat_s;

	always_ff @(posedge clk) begin
		if (advance) begin
			lp_s   <= ex_acc_s[LOG_FRAC] * LEVEL_MAX;
			sh_s   <= ex_sh_s[LOG_FRAC];
			zero_s <= ex_zero_s[LOG_FRAC];
			sat_s  <= ex_sat_s[LOG_FRAC];
		end
	end

	// ---------------- shift, clamp and output register ----------------
	logic [LVL_PW-1:0] lv_c;
	level_t            level_q;

	assign lv_c = lp_s >> sh_s;

	always_ff @(posedge clk) begin
		if (advance) begin
			if (zero_s)
				level_q <= '0;
			else if (sat_s || (lv_c > LVL_PW'(LEVEL_MAX)))
				level_q <= LEVEL_MAX;
			else
				level_q <= lv_c[LEVEL_W-1:0];
		end
	end

	assign rsp.ramp_level = level_q;

endmodule

// ===== hw/rtl/gre_checker.sv =====
// ----------------------------------------------------------------------------
// gre_checker: port-level checks for the gamma ramp entry block
// Watches the item channels and flags stalls or drops at the boundary.
// ----------------------------------------------------------------------------
module gre_checker import gre_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input level_t out_level
);

	// Hold a stalled output item.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_level))
		else $error("output item changed while stalled");

	// An empty output register must never block the input.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// A taken output frees the pipe for a new item in the same cycle.
	a_take_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("input blocked while output drains");

	// Input is refused only while an output item waits.
	a_block_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid && !out_ready)
		else $error("input refused without output stall");

endmodule

bind gamma_ramp_entry gre_checker u_gre_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_level (rsp.ramp_level)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the gamma ramp entry block
// Streams ramp indexes through the block under several register settings,
// predicts each level in fixed point alongside the block and compares every
// returned level in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench import gre_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_W = 8;
	localparam int FRAC = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = REG_BRIGHTNESS;
	reg_t wr_data = '0;

	gre_index_if #(.INDEX_BITS(IDX_W)) req ();
	gre_level_if rsp ();

	gamma_ramp_entry #(.INDEX_BITS(IDX_W), .FRAC_BITS(FRAC)) u_top (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always #10 clk = ~clk;

	// Shadow copy of the registers, changed only while nothing is in flight
	longint bright_q = 4096;
	longint contrast_q = 4096;
	longint inv_gamma_q = 4096;

	logic [IDX_W-1:0] pending_index[$];
	level_t levels_due[$];
	int accepted = 0;
	int popped = 0;
	int failures = 0;
	longint unsigned exp2_root[1:LOG_FRAC];

	function automatic longint unsigned int_sqrt(input longint unsigned v_in);
		longint unsigned v, res, b;
		v = v_in;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Expected level: exact x, log2 by square-and-compare, then exp2 by roots
	function automatic level_t level_for(input logic [IDX_W-1:0] idx);
		longint t, d, xn, logv, e;
		longint unsigned ux, m, fr, acc;
		int p, n;
		t = longint'(idx) * bright_q;
		d = t - (64'sd1 << (IDX_W + FRAC - 1));
		xn = contrast_q * d + (64'sd1 << (IDX_W + 2 * FRAC - 1));
		if (xn <= 0)
			return '0;
		ux = xn;
		p = 0;
		while (p < 62 && (ux >> (p + 1)) != 0)
			p++;
		m = (p >= MANT_BITS) ? ux >> (p - MANT_BITS) : ux << (MANT_BITS - p);
		fr = 0;
		for (int k = 0; k < LOG_FRAC; k++) begin
			m = (m * m) >> MANT_BITS;
			fr = fr << 1;
			if (m >= (64'd2 << MANT_BITS)) begin
				m = m >> 1;
				fr = fr | 64'd1;
			end
		end
		logv = longint'(p - (IDX_W + 2 * FRAC)) * (64'sd1 << LOG_FRAC) + longint'(fr);
		e = (logv * inv_gamma_q) >>> FRAC;
		if (e >= 0)
			return LEVEL_MAX;
		n = int'(e >>> LOG_FRAC);
		if (n < MIN_EXP)
			return '0;
		fr = e & ((64'd1 << LOG_FRAC) - 1);
		acc = 64'd1 << MANT_BITS;
		for (int k = 1; k <= LOG_FRAC; k++)
			if ((fr >> (LOG_FRAC - k)) & 64'd1)
				acc = (acc * exp2_root[k]) >> MANT_BITS;
		acc = (acc * 65535) >> (MANT_BITS - n);
		if (acc > 65535)
			acc = 65535;
		return level_t'(acc);
	endfunction

	// Idle pattern by progress: sender light / receiver heavy, swapped, none
	function automatic bit sender_holds();
		if (accepted < 420) return $urandom_range(0, 99) < 18;
		if (accepted < 840) return $urandom_range(0, 99) < 88;
		return 1'b0;
	endfunction

	function automatic bit receiver_holds();
		if (accepted < 420) return $urandom_range(0, 99) < 88;
		if (accepted < 840) return $urandom_range(0, 99) < 18;
		return 1'b0;
	endfunction

	// Driver: predict on acceptance, then load the next item or drop valid
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.ramp_index <= '0;
		end else begin
			if (req.valid && req.ready) begin
				levels_due.push_back(level_for(req.ramp_index));
				accepted++;
			end
			if (!req.valid || req.ready) begin
				if (pending_index.size() > 0 && !sender_holds()) begin
					req.valid <= 1'b1;
					req.ramp_index <= pending_index.pop_front();
					popped++;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each returned level against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (levels_due.size() == 0) begin
					$error("ramp_level: unexpected item, actual %0d", rsp.ramp_level);
					failures++;
				end else begin
					level_t want;
					want = levels_due.pop_front();
					if (rsp.ramp_level !== want) begin
						$error("ramp_level: expected %0d, actual %0d", want, rsp.ramp_level);
						failures++;
					end
				end
			end
			rsp.ready <= !receiver_holds();
		end
	end

	// Drive the write port and update the shadow copy; caller drops wr_en
	task automatic write_reg(input reg_idx_t idx, input reg_t val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		case (idx)
			REG_BRIGHTNESS: bright_q = val;
			REG_CONTRAST:   contrast_q = val;
			REG_INV_GAMMA:  inv_gamma_q = val;
			default: ;
		endcase
	endtask

	// Wait until every queued item has been driven, accepted and returned
	task automatic drain();
		while (pending_index.size() > 0 || popped != accepted || levels_due.size() > 0)
			@(posedge clk);
	endtask

	task automatic apply_setting(input reg_t b, input reg_t c, input reg_t g);
		drain();
		write_reg(REG_BRIGHTNESS, b);
		write_reg(REG_CONTRAST, c);
		write_reg(REG_INV_GAMMA, g);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_random(input int count);
		for (int i = 0; i < count; i++)
			pending_index.push_back(IDX_W'($urandom_range(0, 255)));
	endtask

	initial begin
		reg_t b, c, g;
		int directed_idx[10] = '{0, 1, 2, 127, 128, 129, 170, 85, 254, 255};
		exp2_root[1] = int_sqrt(64'd2 << (2 * MANT_BITS));
		for (int k = 2; k <= LOG_FRAC; k++)
			exp2_root[k] = int_sqrt(exp2_root[k-1] << MANT_BITS);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset setting, field extremes, midpoint and bit patterns
		foreach (directed_idx[i])
			pending_index.push_back(IDX_W'(directed_idx[i]));
		// Writes to the unused index must leave the registers alone
		drain();
		write_reg(REG_UNUSED, 16'hFFFF);
		wr_en <= 1'b0;
		@(posedge clk);
		pending_index.push_back(8'd0);
		pending_index.push_back(8'd64);
		pending_index.push_back(8'd192);
		pending_index.push_back(8'd255);
		// Zero exponent: anything above zero saturates
		apply_setting(16'd4096, 16'd4096, 16'd0);
		pending_index.push_back(8'd0);
		pending_index.push_back(8'd1);
		pending_index.push_back(8'd200);
		// Large exponent: low indexes underflow deeply to zero
		apply_setting(16'd4096, 16'd4096, 16'hFFFF);
		pending_index.push_back(8'd1);
		pending_index.push_back(8'd16);
		pending_index.push_back(8'd255);

		// Random items across extreme and typical settings
		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0:  begin b = 16'd4096;  c = 16'd4096;  g = 16'd4096;  end
				1:  begin b = 16'd0;     c = 16'd4096;  g = 16'd4096;  end
				2:  begin b = 16'hFFFF;  c = 16'd4096;  g = 16'd4096;  end
				3:  begin b = 16'd4096;  c = 16'd0;     g = 16'd4096;  end
				4:  begin b = 16'd4096;  c = 16'hFFFF;  g = 16'd4096;  end
				5:  begin b = 16'd4096;  c = 16'd4096;  g = 16'd1;     end
				6:  begin b = 16'd4096;  c = 16'd4096;  g = 16'hFFFF;  end
				7:  begin b = 16'hFFFF;  c = 16'hFFFF;  g = 16'hFFFF;  end
				8:  begin b = 16'd4096;  c = 16'd4096;  g = 16'd0;     end
				default: begin
					b = reg_t'($urandom_range(2048, 12288));
					c = reg_t'($urandom_range(1024, 12288));
					g = reg_t'($urandom_range(1024, 16384));
				end
			endcase
			apply_setting(b, c, g);
			push_random(100);
		end

		drain();
		repeat (60) @(posedge clk);
		if (failures == 0 && levels_due.size() == 0)
			$display("gamma_ramp_entry test passed");
		else
			$display("gamma_ramp_entry test failed");
		$finish;
	end

	initial begin
		#10ms;
		$display("gamma_ramp_entry test failed");
		$finish;
	end
endmodule
